>>> hdl/jllt_pkg.sv
// ----------------------------------------------------------------------------
// jllt_pkg
// Shared types and constants for the junction list layout tracker: token
// classes, answer codes, transaction payloads and the stack entry format.
// ----------------------------------------------------------------------------
package jllt_pkg;

	// Default stack depth (number of open junction lists)
	localparam int MAX_DEPTH_DEF = 256;

	// Fixed field widths
	localparam int COL_W  = 15;
	localparam int OPEN_W = 9;

	// Classified lookahead token
	typedef enum logic [2:0] {
		TOK_AND,
		TOK_OR,
		TOK_RDELIM,
		TOK_COMMENT,
		TOK_UNIT,
		TOK_MODEND,
		TOK_EOF,
		TOK_OTHER
	} tok_class_t;

	// Layout answer
	typedef enum logic [1:0] {
		ANS_NONE,
		ANS_INDENT,
		ANS_NEWLINE,
		ANS_DEDENT
	} emit_kind_t;

	// Input transaction
	typedef struct packed {
		tok_class_t       token_class;
		logic [COL_W-1:0] token_column;
		logic             want_outside_text;
		logic             want_comment_text;
		logic             want_indent;
		logic             want_newline;
		logic             want_dedent;
	} token_t;

	// Output transaction
	typedef struct packed {
		emit_kind_t        emit_kind;
		logic [OPEN_W-1:0] open_lists;
		logic              overflow;
	} answer_t;

	// One open junction list: type (1 = disjunction) and alignment column
	typedef struct packed {
		logic             disj;
		logic [COL_W-1:0] column;
	} list_entry_t;

	// Stack update requested by the decision logic
	typedef struct packed {
		logic        push;
		logic        pop;
		list_entry_t entry;
	} stack_op_t;

endpackage

>>> hdl/junction_list_layout_tracker.sv
// ----------------------------------------------------------------------------
// junction_list_layout_tracker
// Tracks open conjunction/disjunction lists and turns each lookahead token
// into an indent, newline, dedent or no answer.
// ----------------------------------------------------------------------------
// The token is held in the input register and its answer in the answer register;
// the move between them waits while a held answer is stalled.
// Throughput: one token per cycle unless a held answer is stalled; the decision
// compares against the top entry register and a pop refills it from the
// read-ahead port of the RAM. Reset clears the list count and both valid flags;
// the stack RAM is not cleared (entries are only read after being pushed).
module junction_list_layout_tracker #(
	parameter int MAX_DEPTH = jllt_pkg::MAX_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              token_valid,
	output logic              token_stall,
	input  jllt_pkg::token_t  token,
	output logic              answer_valid,
	input  logic              answer_stall,
	output jllt_pkg::answer_t answer
);

	localparam int CW = $clog2(MAX_DEPTH + 1);

	logic                  valid_s1;
	jllt_pkg::token_t      token_s1;
	logic                  valid_s2;
	jllt_pkg::answer_t     answer_s2;
	logic                  adv;
	logic                  take;
	logic [CW-1:0]         count;
	logic [CW-1:0]         next_count;
	jllt_pkg::list_entry_t top;
	jllt_pkg::emit_kind_t  kind;
	logic                  overflow;
	jllt_pkg::stack_op_t   op_req;
	jllt_pkg::stack_op_t   op_fire;

	// Handshake: stage 1 moves on when the answer register is free or draining
	assign adv         = valid_s1 && (!valid_s2 || !answer_stall);
	assign token_stall = valid_s1 && !adv;
	assign take        = token_valid && !token_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			token_s1 <= token;
		end
	end

	jllt_decide #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_decide (
		.tok     (token_s1),
		.count   (count),
		.top     (top),
		.kind    (kind),
		.overflow(overflow),
		.op      (op_req)
	);

	// Stack only changes when the transaction moves into the answer register
	always_comb begin
		op_fire      = op_req;
		op_fire.push = op_req.push && adv;
		op_fire.pop  = op_req.pop && adv;
	end

	jllt_stack #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op_fire),
		.count     (count),
		.top       (top),
		.next_count(next_count)
	);

	// Answer register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!answer_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			answer_s2.emit_kind  <= kind;
			answer_s2.open_lists <= jllt_pkg::OPEN_W'(next_count);
			answer_s2.overflow   <= overflow;
		end
	end

	assign answer_valid = valid_s2;
	assign answer       = answer_s2;

	// Stack never holds more lists than it has room for
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(MAX_DEPTH))
		else $error("list count above stack depth");

	// A dropped push never comes with an answer
	a_ovf_none: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && answer_s2.overflow |-> answer_s2.emit_kind == jllt_pkg::ANS_NONE)
		else $error("overflow flagged with a layout answer");

	// An indent grows the stack by exactly one
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		op_fire.push |=> count == $past(count) + CW'(1))
		else $error("push did not increment the list count");

endmodule

>>> hdl/jllt_ram.sv
// ----------------------------------------------------------------------------
// jllt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module jllt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/jllt_stack.sv
// ----------------------------------------------------------------------------
// jllt_stack
// List stack: top entry and count in registers, all entries in a RAM. The
// RAM read port always fetches the entry just below the top so a pop can
// refill the top register in the same cycle.
// ----------------------------------------------------------------------------
module jllt_stack #(
	parameter int MAX_DEPTH = jllt_pkg::MAX_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  jllt_pkg::stack_op_t            op,
	output logic [$clog2(MAX_DEPTH+1)-1:0] count,
	output jllt_pkg::list_entry_t          top,
	output logic [$clog2(MAX_DEPTH+1)-1:0] next_count
);

	localparam int CW = $clog2(MAX_DEPTH + 1);
	localparam int AW = $clog2(MAX_DEPTH);
	localparam int EW = $bits(jllt_pkg::list_entry_t);

	logic [CW-1:0]         count_q;
	jllt_pkg::list_entry_t top_q;
	logic [CW-1:0]         below_idx;
	logic [EW-1:0]         below_data;

	// Count after this cycle's update
	always_comb begin
		next_count = count_q;
		if (op.push) begin
			next_count = count_q + CW'(1);
		end else if (op.pop) begin
			next_count = count_q - CW'(1);
		end
	end

	// Read ahead: entry below the top after the update (meaningful when two or more open)
	assign below_idx = next_count - CW'(2);

	jllt_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (op.push),
		.waddr(count_q[AW-1:0]),
		.wdata(op.entry),
		.raddr(below_idx[AW-1:0]),
		.rdata(below_data)
	);

	// Count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= next_count;
		end
	end

	// Top entry register
	always_ff @(posedge clk) begin
		if (op.push) begin
			top_q <= op.entry;
		end else if (op.pop) begin
			top_q <= jllt_pkg::list_entry_t'(below_data);
		end
	end

	assign count = count_q;
	assign top   = top_q;

endmodule

>>> hdl/jllt_decide.sv
// ----------------------------------------------------------------------------
// jllt_decide
// Layout decision: compares one token with the top open list and picks the
// answer (indent, newline, dedent or nothing) and the stack update.
// ----------------------------------------------------------------------------
module jllt_decide #(
	parameter int MAX_DEPTH = jllt_pkg::MAX_DEPTH_DEF
) (
	input  jllt_pkg::token_t                tok,
	input  logic [$clog2(MAX_DEPTH+1)-1:0]  count,
	input  jllt_pkg::list_entry_t           top,
	output jllt_pkg::emit_kind_t            kind,
	output logic                            overflow,
	output jllt_pkg::stack_op_t             op
);

	localparam int CW = $clog2(MAX_DEPTH + 1);

	logic empty;
	logic full;
	logic col_gt;
	logic col_eq;
	logic tok_disj;
	logic active;
	logic do_push;
	logic do_pop;

	// Stack status and column compare (empty stack counts as column -1)
	assign empty    = (count == '0);
	assign full     = (count == CW'(MAX_DEPTH));
	assign col_gt   = empty || (tok.token_column > top.column);
	assign col_eq   = !empty && (tok.token_column == top.column);
	assign tok_disj = (tok.token_class == jllt_pkg::TOK_OR);

	// Error recovery and text scanning both leave the state alone
	assign active = !tok.want_outside_text && !tok.want_comment_text &&
		(tok.want_indent || tok.want_newline || tok.want_dedent);

	// Answer per token class
	always_comb begin
		kind     = jllt_pkg::ANS_NONE;
		overflow = 1'b0;
		do_push  = 1'b0;
		do_pop   = 1'b0;
		if (active) begin
			unique case (tok.token_class)
				jllt_pkg::TOK_AND, jllt_pkg::TOK_OR: begin
					if (col_gt) begin
						if (tok.want_indent) begin
							if (full) begin
								overflow = 1'b1;
							end else begin
								do_push = 1'b1;
							end
						end
					end else if (col_eq && (top.disj == tok_disj)) begin
						kind = jllt_pkg::ANS_NEWLINE;
					end else begin
						do_pop = 1'b1;
					end
				end
				jllt_pkg::TOK_RDELIM: begin
					do_pop = !empty && tok.want_dedent;
				end
				jllt_pkg::TOK_COMMENT: begin
					do_pop = 1'b0;
				end
				jllt_pkg::TOK_UNIT, jllt_pkg::TOK_MODEND, jllt_pkg::TOK_EOF: begin
					do_pop = !empty;
				end
				jllt_pkg::TOK_OTHER: begin
					// column at or left of the top list closes it
					do_pop = !col_gt;
				end
				default: begin
					do_pop = 1'b0;
				end
			endcase
			if (do_push) begin
				kind = jllt_pkg::ANS_INDENT;
			end else if (do_pop) begin
				kind = jllt_pkg::ANS_DEDENT;
			end
		end
	end

	// Stack update
	always_comb begin
		op.push         = do_push;
		op.pop          = do_pop;
		op.entry.disj   = tok_disj;
		op.entry.column = tok.token_column;
	end

endmodule
